// ----- rtl/eaipid_pkg.sv -----
// Shared types and constants for the encoder angle PID core.
package eaipid_pkg;

    localparam int TARGET_W = 24;
    localparam int GAIN_W   = 16;
    localparam int DPC_W    = 16;
    localparam int ERR_W    = 25;
    localparam int ACC_W    = 40;
    localparam int DUTY_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SUM_W    = 46;

    localparam logic [TARGET_W-1:0] ANGLE_MAX = {TARGET_W{1'b1}};
    localparam logic [DUTY_W-1:0]   DUTY_MAX  = 7'd100;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 24'd92160;
    localparam logic [DPC_W-1:0]    DPC_RESET    = 16'd14043;

    // input opcodes
    localparam logic [1:0] OP_EDGE_C = 2'd0;
    localparam logic [1:0] OP_EDGE_D = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_ZERO   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DPC        = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANG,
        ST_ERR,
        ST_MP,
        ST_MI,
        ST_MD,
        ST_SUM,
        ST_ACC
    } state_t;

    typedef enum logic [1:0] {
        MUL_ANGLE,
        MUL_PROP,
        MUL_INTEG,
        MUL_DERIV
    } mul_sel_t;

    typedef struct packed {
        logic     cnt_step;
        logic     cnt_up;
        logic     cnt_clr;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     err_load;
        logic     sum_clr;
        logic     sum_add;
        logic     commit;
    } dp_cmd_t;

endpackage

// ----- rtl/eaipid_ctrl.sv -----
// Sequencer for count updates and the control tick.
module eaipid_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic                 level_c,
    input  logic                 level_d,
    output logic                 out_valid,
    input  logic                 out_stall,
    output eaipid_pkg::dp_cmd_t  cmd
);

    eaipid_pkg::state_t state_reg;
    eaipid_pkg::state_t state_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               in_take;
    logic               same_lvl;
    logic               out_busy;

    assign in_stall  = (state_reg != eaipid_pkg::ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign same_lvl  = (level_c == level_d);
    assign out_busy  = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eaipid_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            eaipid_pkg::ST_IDLE:
            begin
                if (in_take && opcode == eaipid_pkg::OP_TICK)
                    state_next = eaipid_pkg::ST_ANG;
            end
            eaipid_pkg::ST_ANG: state_next = eaipid_pkg::ST_ERR;
            eaipid_pkg::ST_ERR: state_next = eaipid_pkg::ST_MP;
            eaipid_pkg::ST_MP:  state_next = eaipid_pkg::ST_MI;
            eaipid_pkg::ST_MI:  state_next = eaipid_pkg::ST_MD;
            eaipid_pkg::ST_MD:  state_next = eaipid_pkg::ST_SUM;
            eaipid_pkg::ST_SUM: state_next = eaipid_pkg::ST_ACC;
            eaipid_pkg::ST_ACC:
            begin
                // hold until the output register can take the result
                if (!out_busy)
                    state_next = eaipid_pkg::ST_IDLE;
            end
            default: state_next = eaipid_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = eaipid_pkg::MUL_ANGLE;
        out_valid_next = out_busy;
        case (state_reg)
            eaipid_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    case (opcode)
                        eaipid_pkg::OP_EDGE_C:
                        begin
                            cmd.cnt_step = 1'b1;
                            cmd.cnt_up   = same_lvl;
                        end
                        eaipid_pkg::OP_EDGE_D:
                        begin
                            cmd.cnt_step = 1'b1;
                            cmd.cnt_up   = !same_lvl;
                        end
                        eaipid_pkg::OP_ZERO: cmd.cnt_clr = 1'b1;
                        default: ;
                    endcase
                end
            end
            eaipid_pkg::ST_ANG:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = eaipid_pkg::MUL_ANGLE;
            end
            eaipid_pkg::ST_ERR: cmd.err_load = 1'b1;
            eaipid_pkg::ST_MP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = eaipid_pkg::MUL_PROP;
                cmd.sum_clr = 1'b1;
            end
            eaipid_pkg::ST_MI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = eaipid_pkg::MUL_INTEG;
                cmd.sum_add = 1'b1;
            end
            eaipid_pkg::ST_MD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = eaipid_pkg::MUL_DERIV;
                cmd.sum_add = 1'b1;
            end
            eaipid_pkg::ST_SUM: cmd.sum_add = 1'b1;
            eaipid_pkg::ST_ACC:
            begin
                if (!out_busy)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result committed but output valid not raised");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("result committed over a held transaction");

    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && opcode == eaipid_pkg::OP_TICK)
            |=> state_reg == eaipid_pkg::ST_ANG)
        else $error("accepted tick did not start the angle step");

    a_count_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_step || cmd.cnt_clr) |-> (state_reg == eaipid_pkg::ST_IDLE && in_valid))
        else $error("count changed outside an accepted transaction");
`endif

endmodule

// ----- rtl/eaipid_dp.sv -----
// Datapath: position counter, shared multiplier, PID accumulator and result registers.
module eaipid_dp #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  eaipid_pkg::dp_cmd_t                    cmd,
    input  logic                                   cfg_we,
    input  logic [eaipid_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [eaipid_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [eaipid_pkg::DUTY_W-1:0]          duty,
    output logic signed [eaipid_pkg::ACC_W-1:0]    control_value,
    output logic signed [eaipid_pkg::ERR_W-1:0]    angle_error,
    output logic [eaipid_pkg::TARGET_W-1:0]        measured_angle
);

    localparam int ERR_W  = eaipid_pkg::ERR_W;
    localparam int ACC_W  = eaipid_pkg::ACC_W;
    localparam int PROD_W = eaipid_pkg::PROD_W;
    localparam int SUM_W  = eaipid_pkg::SUM_W;
    localparam int DELTA_W = SUM_W - 8;

    // configuration
    logic [eaipid_pkg::GAIN_W-1:0]   kp_reg, ki_reg, kd_reg;
    logic [eaipid_pkg::TARGET_W-1:0] target_reg;
    logic [eaipid_pkg::DPC_W-1:0]    dpc_reg;

    // state
    logic [COUNT_WIDTH-1:0]     count_reg;
    logic signed [ERR_W-1:0]    e1_reg, e2_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    // working registers
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       sat_reg;
    logic [eaipid_pkg::TARGET_W-1:0] ang_reg;
    logic signed [ERR_W-1:0]    e_reg;
    logic signed [ERR_W:0]      d1_reg;
    logic signed [ERR_W+1:0]    d2_reg;
    logic signed [SUM_W-1:0]    sum_reg;

    // result registers
    logic [eaipid_pkg::DUTY_W-1:0]   duty_reg;
    logic signed [ACC_W-1:0]         ctl_reg;
    logic signed [ERR_W-1:0]         err_out_reg;
    logic [eaipid_pkg::TARGET_W-1:0] ang_out_reg;

    logic [COUNT_WIDTH-1:0]          mag;
    logic [63:0]                     mag64;
    logic signed [eaipid_pkg::MUL_A_W-1:0] mul_a;
    logic signed [eaipid_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]        prod;
    logic [eaipid_pkg::TARGET_W-1:0] ang_next;
    logic signed [ERR_W-1:0]         e_next;
    logic signed [DELTA_W-1:0]       delta;
    logic signed [ACC_W:0]           acc_wide;
    logic signed [ACC_W-1:0]         acc_next;
    logic [ACC_W-1:0]                acc_abs;
    logic [ACC_W-9:0]                duty_q;
    logic [eaipid_pkg::DUTY_W-1:0]   duty_next;

    // magnitude of the signed count; the most negative value maps to 2^(W-1)
    assign mag   = count_reg[COUNT_WIDTH-1] ? (~count_reg + 1'b1) : count_reg;
    assign mag64 = 64'(mag);

    always_comb
    begin
        mul_b = '0;
        case (cmd.mul_sel)
            eaipid_pkg::MUL_ANGLE:
            begin
                mul_a = {1'b0, mag64[31:0]};
                mul_b = {1'b0, dpc_reg};
            end
            eaipid_pkg::MUL_PROP:
            begin
                mul_a = {{(eaipid_pkg::MUL_A_W-ERR_W-1){d1_reg[ERR_W]}}, d1_reg};
                mul_b = {1'b0, kp_reg};
            end
            eaipid_pkg::MUL_INTEG:
            begin
                mul_a = {{(eaipid_pkg::MUL_A_W-ERR_W){e_reg[ERR_W-1]}}, e_reg};
                mul_b = {1'b0, ki_reg};
            end
            eaipid_pkg::MUL_DERIV:
            begin
                mul_a = {{(eaipid_pkg::MUL_A_W-ERR_W-2){d2_reg[ERR_W+1]}}, d2_reg};
                mul_b = {1'b0, kd_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // angle from the registered product, saturated to 24 bits
    assign ang_next = (sat_reg || (|prod_reg[47:32])) ? eaipid_pkg::ANGLE_MAX
                                                      : prod_reg[31:8];
    assign e_next = $signed({1'b0, target_reg}) - $signed({1'b0, ang_next});

    // floor of sum / 256, then a saturating add into the accumulator
    assign delta    = sum_reg[SUM_W-1:8];
    assign acc_wide = {acc_reg[ACC_W-1], acc_reg}
                    + {{(ACC_W+1-DELTA_W){delta[DELTA_W-1]}}, delta};
    always_comb
    begin
        if (acc_wide[ACC_W] != acc_wide[ACC_W-1])
            acc_next = acc_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                       : {1'b0, {(ACC_W-1){1'b1}}};
        else
            acc_next = acc_wide[ACC_W-1:0];
    end
    assign acc_abs   = acc_next[ACC_W-1] ? (~acc_next + 1'b1) : acc_next;
    assign duty_q    = acc_abs[ACC_W-1:8];
    assign duty_next = (duty_q > {{(ACC_W-8-eaipid_pkg::DUTY_W){1'b0}}, eaipid_pkg::DUTY_MAX})
                     ? eaipid_pkg::DUTY_MAX : duty_q[eaipid_pkg::DUTY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= '0;
            ki_reg     <= '0;
            kd_reg     <= '0;
            target_reg <= eaipid_pkg::TARGET_RESET;
            dpc_reg    <= eaipid_pkg::DPC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                eaipid_pkg::REG_GAIN_PROP:  kp_reg     <= cfg_data[eaipid_pkg::GAIN_W-1:0];
                eaipid_pkg::REG_GAIN_INTEG: ki_reg     <= cfg_data[eaipid_pkg::GAIN_W-1:0];
                eaipid_pkg::REG_GAIN_DERIV: kd_reg     <= cfg_data[eaipid_pkg::GAIN_W-1:0];
                eaipid_pkg::REG_TARGET:     target_reg <= cfg_data;
                eaipid_pkg::REG_DPC:        dpc_reg    <= cfg_data[eaipid_pkg::DPC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            e1_reg    <= '0;
            e2_reg    <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            if (cmd.cnt_clr)
                count_reg <= '0;
            else if (cmd.cnt_step)
                count_reg <= cmd.cnt_up ? count_reg + 1'b1 : count_reg - 1'b1;
            if (cmd.commit)
            begin
                acc_reg <= acc_next;
                e2_reg  <= e1_reg;
                e1_reg  <= e_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= prod;
        if (cmd.mul_en && cmd.mul_sel == eaipid_pkg::MUL_ANGLE)
            sat_reg <= (|mag64[63:32]) && (dpc_reg != '0);
        if (cmd.err_load)
        begin
            ang_reg <= ang_next;
            e_reg   <= e_next;
            d1_reg  <= {e_next[ERR_W-1], e_next} - {e1_reg[ERR_W-1], e1_reg};
            d2_reg  <= {{2{e_next[ERR_W-1]}}, e_next}
                     - {e1_reg[ERR_W-1], e1_reg, 1'b0}
                     + {{2{e2_reg[ERR_W-1]}}, e2_reg};
        end
        if (cmd.sum_clr)
            sum_reg <= '0;
        else if (cmd.sum_add)
            sum_reg <= sum_reg + prod_reg[SUM_W-1:0];
        if (cmd.commit)
        begin
            duty_reg    <= duty_next;
            ctl_reg     <= acc_next;
            err_out_reg <= e_reg;
            ang_out_reg <= ang_reg;
        end
    end

    assign duty           = duty_reg;
    assign control_value  = ctl_reg;
    assign angle_error    = err_out_reg;
    assign measured_angle = ang_out_reg;

endmodule

// ----- rtl/encoder_angle_incremental_pid_core.sv -----
// Top level: quadrature position counter with incremental angle PID controller.
// Edge and zero-count transactions produce no result. A control tick is accepted
// in idle and then stalls the input for seven sequencer steps; its result is
// committed in the last step, which waits while the output is held. A single
// shared 33x17 multiplier serves in turn the angle and the three gain products.
// Reset clears the count, error history, accumulator and output valid, and
// loads the register defaults (gains 0, target 92160, degrees_per_count 14043).
module encoder_angle_incremental_pid_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             opcode,
    input  logic                                   level_c,
    input  logic                                   level_d,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [eaipid_pkg::DUTY_W-1:0]          duty,
    output logic signed [eaipid_pkg::ACC_W-1:0]    control_value,
    output logic signed [eaipid_pkg::ERR_W-1:0]    angle_error,
    output logic [eaipid_pkg::TARGET_W-1:0]        measured_angle,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [eaipid_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [eaipid_pkg::CFG_DATA_W-1:0]      cfg_data
);

    eaipid_pkg::dp_cmd_t cmd;

    // registers are plain flops, always ready
    assign cfg_ready = 1'b1;

    eaipid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .level_c   (level_c),
        .level_d   (level_d),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    eaipid_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .duty           (duty),
        .control_value  (control_value),
        .angle_error    (angle_error),
        .measured_angle (measured_angle)
    );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the encoder angle PID core: random and directed transactions.
module tb;
    import eaipid_pkg::*;

    localparam int     COUNT_W         = 32;
    localparam int     RANDOM_PHASES   = 6;
    localparam int     ITEMS_PER_PHASE = 250;
    localparam int     BURST_STEPS     = 150;
    localparam int     NEG_TICKS       = 40;
    localparam int     SAT_TICKS       = 280;
    localparam int     SETTLE_CYCLES   = 12;
    localparam int     CYCLE_LIMIT     = 1000000;
    localparam longint ACC_TOP         = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_BOTTOM      = -ACC_TOP - 1;

    typedef struct {
        logic [DUTY_W-1:0]          duty;
        logic signed [ACC_W-1:0]    control;
        logic signed [ERR_W-1:0]    err;
        logic [TARGET_W-1:0]        angle;
    } pid_out_t;

    // Tracks count, error history and accumulator; queues the output each tick should give.
    class pid_tracker;
        logic [GAIN_W-1:0]         gain_p;
        logic [GAIN_W-1:0]         gain_i;
        logic [GAIN_W-1:0]         gain_d;
        logic [TARGET_W-1:0]       target;
        logic [DPC_W-1:0]          deg_per_count;
        logic signed [COUNT_W-1:0] position;
        longint                    err_last;
        longint                    err_older;
        longint                    accum;
        pid_out_t                  expected_outputs[$];
        int unsigned               mismatches;

        function new();
            gain_p        = '0;
            gain_i        = '0;
            gain_d        = '0;
            target        = TARGET_RESET;
            deg_per_count = DPC_RESET;
            position      = '0;
            err_last      = 0;
            err_older     = 0;
            accum         = 0;
            mismatches    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAIN_PROP:  gain_p = data[GAIN_W-1:0];
                REG_GAIN_INTEG: gain_i = data[GAIN_W-1:0];
                REG_GAIN_DERIV: gain_d = data[GAIN_W-1:0];
                REG_TARGET:     target = data[TARGET_W-1:0];
                REG_DPC:        deg_per_count = data[DPC_W-1:0];
                default:        ;
            endcase
        endfunction

        function void accept_command(logic [1:0] op, logic c, logic d);
            longint   mag;
            longint   ang;
            longint   err;
            longint   pid_sum;
            longint   next_acc;
            longint   duty_full;
            pid_out_t res;
            case (op)
                OP_EDGE_C: position = (c == d) ? position + 1 : position - 1;
                OP_EDGE_D: position = (c == d) ? position - 1 : position + 1;
                OP_ZERO:   position = '0;
                default:
                begin
                    mag = (position < 0) ? -longint'(position) : longint'(position);
                    ang = (mag * longint'(deg_per_count)) >>> 8;
                    if (ang > longint'(ANGLE_MAX))
                        ang = longint'(ANGLE_MAX);
                    err = longint'(target) - ang;
                    pid_sum = longint'(gain_p) * (err - err_last)
                            + longint'(gain_i) * err
                            + longint'(gain_d) * (err - 2 * err_last + err_older);
                    // arithmetic shift floors toward minus infinity
                    next_acc = accum + (pid_sum >>> 8);
                    if (next_acc > ACC_TOP)
                        next_acc = ACC_TOP;
                    if (next_acc < ACC_BOTTOM)
                        next_acc = ACC_BOTTOM;
                    accum     = next_acc;
                    err_older = err_last;
                    err_last  = err;
                    duty_full = ((next_acc < 0) ? -next_acc : next_acc) >>> 8;
                    if (duty_full > longint'(DUTY_MAX))
                        duty_full = longint'(DUTY_MAX);
                    res.duty    = duty_full[DUTY_W-1:0];
                    res.control = next_acc[ACC_W-1:0];
                    res.err     = err[ERR_W-1:0];
                    res.angle   = ang[TARGET_W-1:0];
                    expected_outputs.push_back(res);
                end
            endcase
        endfunction

        function void check_pid_output(pid_out_t got);
            pid_out_t exp;
            if (expected_outputs.size() == 0)
            begin
                $display("%0t unexpected output: duty %0d control %0d error %0d angle %0d",
                         $time, got.duty, got.control, got.err, got.angle);
                mismatches++;
                return;
            end
            exp = expected_outputs.pop_front();
            if (got.duty !== exp.duty)
            begin
                $display("%0t duty: expected %0d, actual %0d", $time, exp.duty, got.duty);
                mismatches++;
            end
            if (got.control !== exp.control)
            begin
                $display("%0t control_value: expected %0d, actual %0d",
                         $time, exp.control, got.control);
                mismatches++;
            end
            if (got.err !== exp.err)
            begin
                $display("%0t angle_error: expected %0d, actual %0d", $time, exp.err, got.err);
                mismatches++;
            end
            if (got.angle !== exp.angle)
            begin
                $display("%0t measured_angle: expected %0d, actual %0d",
                         $time, exp.angle, got.angle);
                mismatches++;
            end
        endfunction
    endclass

    logic                       clk            = 1'b0;
    logic                       rst_n          = 1'b0;
    logic                       in_valid       = 1'b0;
    logic                       in_stall;
    logic [1:0]                 opcode         = OP_EDGE_C;
    logic                       level_c        = 1'b0;
    logic                       level_d        = 1'b0;
    logic                       out_valid;
    logic                       out_stall      = 1'b0;
    logic [DUTY_W-1:0]          duty;
    logic signed [ACC_W-1:0]    control_value;
    logic signed [ERR_W-1:0]    angle_error;
    logic [TARGET_W-1:0]        measured_angle;
    logic                       cfg_valid      = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index      = REG_GAIN_PROP;
    logic [CFG_DATA_W-1:0]      cfg_data       = '0;

    pid_tracker  tracker;
    pid_out_t    observed;
    int          send_idle_pct  = 31;
    int          stall_pct      = 46;
    int unsigned cycle_count    = 0;

    encoder_angle_incremental_pid_core #(
        .COUNT_WIDTH(COUNT_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .level_c(level_c),
        .level_d(level_d),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .duty(duty),
        .control_value(control_value),
        .angle_error(angle_error),
        .measured_angle(measured_angle),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("encoder_angle_incremental_pid_core verification failed");
            $finish;
        end
    end

    // Output side: values read here are the ones present before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            observed.duty    = duty;
            observed.control = control_value;
            observed.err     = angle_error;
            observed.angle   = measured_angle;
            tracker.check_pid_output(observed);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Level on D that makes an edge on the given channel step the count up or down.
    function automatic logic level_for_step(logic [1:0] op, logic c, logic up);
        if (op == OP_EDGE_C)
            return up ? c : ~c;
        return up ? ~c : c;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic c, input logic d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        level_c  <= c;
        level_d  <= d;
        do
            @(posedge clk);
        while (in_stall);
        tracker.accept_command(op, c, d);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_register(idx, data);
    endtask

    task automatic configure(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                             input logic [GAIN_W-1:0] kd, input logic [TARGET_W-1:0] tgt,
                             input logic [DPC_W-1:0] dpc, input bit spare);
        write_register(REG_GAIN_PROP, CFG_DATA_W'(kp));
        write_register(REG_GAIN_INTEG, CFG_DATA_W'(ki));
        write_register(REG_GAIN_DERIV, CFG_DATA_W'(kd));
        write_register(REG_TARGET, CFG_DATA_W'(tgt));
        write_register(REG_DPC, CFG_DATA_W'(dpc));
        // unused indexes must leave every register alone
        if (spare)
            for (int i = int'(REG_DPC) + 1; i < (1 << CFG_IDX_W); i++)
                write_register(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_setting(int width);
        logic [CFG_DATA_W-1:0] mask;
        mask = CFG_DATA_W'((64'd1 << width) - 1);
        case ($urandom_range(3))
            0:       return '0;
            1:       return mask;
            default: return CFG_DATA_W'($urandom) & mask;
        endcase
    endfunction

    initial
    begin
        int         up_bias;
        int         roll;
        logic       c;
        logic [1:0] op;

        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every level pair on both channels, ticks between, levels on tick/zero ignored
        send_item(OP_TICK, 1'b0, 1'b0);
        send_item(OP_EDGE_C, 1'b0, 1'b0);
        send_item(OP_TICK, 1'b1, 1'b1);
        send_item(OP_EDGE_C, 1'b0, 1'b1);
        send_item(OP_EDGE_C, 1'b1, 1'b0);
        send_item(OP_TICK, 1'b0, 1'b1);
        send_item(OP_EDGE_C, 1'b1, 1'b1);
        send_item(OP_EDGE_D, 1'b0, 1'b0);
        send_item(OP_EDGE_D, 1'b0, 1'b1);
        send_item(OP_EDGE_D, 1'b1, 1'b0);
        send_item(OP_TICK, 1'b1, 1'b0);
        send_item(OP_EDGE_D, 1'b1, 1'b1);
        send_item(OP_EDGE_D, 1'b1, 1'b1);
        send_item(OP_TICK, 1'b0, 1'b0);
        send_item(OP_ZERO, 1'b1, 1'b1);
        send_item(OP_TICK, 1'b0, 1'b1);
        send_item(OP_ZERO, 1'b0, 1'b0);
        send_item(OP_TICK, 1'b1, 1'b0);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 2)
            begin
                send_idle_pct = 46;
                stall_pct     = 31;
            end
            if (phase == 4)
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            if (phase == 1)
                configure('1, '1, '1, ANGLE_MAX, '1, 1'b0);
            else if (phase == 2)
                configure('0, '0, '0, '0, '0, 1'b0);
            else
                configure(GAIN_W'(pick_setting(GAIN_W)), GAIN_W'(pick_setting(GAIN_W)),
                          GAIN_W'(pick_setting(GAIN_W)), TARGET_W'(pick_setting(TARGET_W)),
                          DPC_W'(pick_setting(DPC_W)), phase == 0);
            up_bias = $urandom_range(20, 80);
            repeat (ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(99);
                c    = 1'($urandom_range(1));
                if (roll < 22)
                    send_item(OP_TICK, c, 1'($urandom_range(1)));
                else if (roll < 30)
                    send_item(OP_ZERO, c, 1'($urandom_range(1)));
                else
                begin
                    op = $urandom_range(1) ? OP_EDGE_C : OP_EDGE_D;
                    send_item(op, c, level_for_step(op, c, $urandom_range(99) < up_bias));
                end
            end
            drain();
        end

        // drive the count negative and tick against a zero target for a negative error
        configure('1, '1, '1, '0, '1, 1'b0);
        repeat (BURST_STEPS)
        begin
            c  = 1'($urandom_range(1));
            op = $urandom_range(1) ? OP_EDGE_C : OP_EDGE_D;
            send_item(op, c, level_for_step(op, c, 1'b0));
        end
        repeat (NEG_TICKS) send_item(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
        drain();

        // swing the accumulator all the way to the positive limit
        configure('1, '1, '1, ANGLE_MAX, '1, 1'b0);
        send_item(OP_ZERO, 1'($urandom_range(1)), 1'($urandom_range(1)));
        repeat (SAT_TICKS) send_item(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
        drain();

        if (tracker.mismatches == 0 && tracker.expected_outputs.size() == 0)
            $display("encoder_angle_incremental_pid_core verification clean");
        else
            $display("encoder_angle_incremental_pid_core verification failed");
        $finish;
    end
endmodule

// ----- encoder_angle_incremental_pid_core.f -----
rtl/eaipid_pkg.sv
rtl/eaipid_ctrl.sv
rtl/eaipid_dp.sv
rtl/encoder_angle_incremental_pid_core.sv
tb/tb.sv
